@@ sv/usef_pkg.sv @@
// ----------------------------------------------------------------------------
// usef_pkg: shared types and constants of the spanning edge filter
// Field widths of the edge and result transactions, the kept-edge counter
// limit and the status bundle that the sequencer hands to the top level.
// ----------------------------------------------------------------------------
package usef_pkg;

    localparam int VERTEX_W         = 10;
    localparam int WEIGHT_W         = 32;
    localparam int COUNT_W          = 16;
    localparam int DEF_VERTEX_COUNT = 1024;

    typedef logic        [VERTEX_W-1:0] t_vertex;
    typedef logic signed [WEIGHT_W-1:0] t_weight;
    typedef logic        [COUNT_W-1:0]  t_count;

    localparam t_count COUNT_MAX = {COUNT_W{1'b1}};

    // Sequencer status as seen by the top level
    typedef struct packed {
        logic    idle;  // ready for a new edge
        logic    done;  // result is handed over this cycle
        logic    keep;  // edge joined two components
        t_vertex lo;    // smaller endpoint
        t_vertex hi;    // larger endpoint
    } t_core_stat;

endpackage

@@ sv/union_find_spanning_edge_filter.sv @@
// ----------------------------------------------------------------------------
// union_find_spanning_edge_filter: Kruskal edge filter on a union-find table
// Takes sorted weighted edges, keeps those that join two components and
// reports every edge with its endpoints ordered and a saturating kept count.
//
//   channel  direction  handshake             payload
//   edge     in         i_valid / o_ready     i_vertex_a, i_vertex_b,
//                                              i_edge_weight
//   result   out        o_valid / i_ready     o_keep_edge, o_low_vertex,
//                                              o_high_vertex, o_weight_out,
//                                              o_kept_total
//
// An edge is worked on from its input transaction until the next one can be
// accepted: the sequencer walks each endpoint to its root, one registered read
// of the parent memory per hop, walks both paths again to compress them and,
// when the edge is kept, writes the two link entries. Self-loops and
// out-of-range endpoints skip the walks and go straight to the result.
// After reset the parent memory is cleared with o_ready low. A stalled result
// holds in the output register; the next edge is still accepted and waits in
// the sequencer until the register frees.
// ----------------------------------------------------------------------------
module union_find_spanning_edge_filter import usef_pkg::*; #(
    parameter int VERTEX_COUNT = DEF_VERTEX_COUNT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_vertex i_vertex_a,
    input  t_vertex i_vertex_b,
    input  t_weight i_edge_weight,
    output logic    o_valid,
    input  logic    i_ready,
    output logic    o_keep_edge,
    output t_vertex o_low_vertex,
    output t_vertex o_high_vertex,
    output t_weight o_weight_out,
    output t_count  o_kept_total
);

    t_core_stat w_stat;
    logic       w_in_fire;
    logic       w_out_free;

    logic    r_out_valid, n_out_valid;
    t_count  r_count,     n_count;
    t_weight r_weight;
    logic    r_keep;
    t_vertex r_lo;
    t_vertex r_hi;
    t_weight r_out_weight;
    t_count  r_out_count;

    assign o_ready    = w_stat.idle;
    assign w_in_fire  = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;

    usef_core #(
        .VERTEX_COUNT (VERTEX_COUNT)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_fire),
        .i_vertex_a (i_vertex_a),
        .i_vertex_b (i_vertex_b),
        .i_out_free (w_out_free),
        .o_stat     (w_stat)
    );

    // Advance the kept count, saturating at its maximum
    always_comb begin
        n_count = r_count;
        if (w_stat.done && w_stat.keep && (r_count != COUNT_MAX)) begin
            n_count = r_count + t_count'(1);
        end
    end

    // Output register valid: load on a finished edge, drop on a transaction
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_stat.done) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    // Hold the weight while the edge is worked on
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_weight <= i_edge_weight;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_stat.done) begin
            r_keep       <= w_stat.keep;
            r_lo         <= w_stat.lo;
            r_hi         <= w_stat.hi;
            r_out_weight <= r_weight;
            r_out_count  <= n_count;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_keep_edge   = r_keep;
    assign o_low_vertex  = r_lo;
    assign o_high_vertex = r_hi;
    assign o_weight_out  = r_out_weight;
    assign o_kept_total  = r_out_count;

    // A kept edge never has equal endpoints
    a_keep_no_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.done && w_stat.keep) |-> (w_stat.lo < w_stat.hi))
        else $error("kept edge with lo not below hi");

    // The kept count moves only when a kept edge finishes
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_stat.done && w_stat.keep) |=> (r_count == $past(r_count)))
        else $error("kept count changed without a kept edge");

    // One edge at a time: ready drops right after a transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> !o_ready)
        else $error("ready stayed high after an input transaction");

endmodule

@@ sv/usef_ram.sv @@
// ----------------------------------------------------------------------------
// usef_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module usef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/usef_core.sv @@
// ----------------------------------------------------------------------------
// usef_core: union-find sequencer around the parent memory
// Walks both endpoints to their roots, compresses both paths so every
// visited vertex points at its root, then joins the smaller tree under the
// larger. Each parent entry is a root flag over a payload: tree size minus
// one for a root, parent index otherwise. At most one memory read and at most one
// memory write per cycle.
// ----------------------------------------------------------------------------
module usef_core import usef_pkg::*; #(
    parameter int VERTEX_COUNT = DEF_VERTEX_COUNT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_vertex    i_vertex_a,
    input  t_vertex    i_vertex_b,
    input  logic       i_out_free,
    output t_core_stat o_stat
);

    localparam int AW = $clog2(VERTEX_COUNT);
    localparam int EW = AW + 1;

    typedef logic [AW-1:0] t_addr;
    typedef logic [EW-1:0] t_entry;

    localparam t_addr  LAST_ADDR  = t_addr'(VERTEX_COUNT - 1);
    localparam t_entry ROOT_ONE   = {1'b1, {AW{1'b0}}};

    typedef enum logic [8:0] {
        S_CLEAR      = 9'b000000001,
        S_IDLE       = 9'b000000010,
        S_FIND_LO    = 9'b000000100,
        S_FIND_HI    = 9'b000001000,
        S_COMP_LO    = 9'b000010000,
        S_COMP_HI    = 9'b000100000,
        S_LINK_ROOT  = 9'b001000000,
        S_LINK_CHILD = 9'b010000000,
        S_DONE       = 9'b100000000
    } t_state;

    t_state  r_state, n_state;
    t_addr   r_clr,   n_clr;
    t_addr   r_cur,   n_cur;
    t_addr   r_ri,    n_ri;
    t_addr   r_rj,    n_rj;
    t_addr   r_si,    n_si;
    t_addr   r_sj,    n_sj;
    t_vertex r_lo,    n_lo;
    t_vertex r_hi,    n_hi;
    logic    r_keep,  n_keep;

    logic    w_rd_en;
    t_addr   w_rd_addr;
    t_entry  w_rd_data;
    logic    w_wr_en;
    t_addr   w_wr_addr;
    t_entry  w_wr_data;

    logic    w_root;
    t_addr   w_pay;
    logic    w_a_lt_b;
    t_vertex w_lo_in;
    t_vertex w_hi_in;
    logic    w_in_ok;
    logic    w_ri_wins;
    t_addr   w_joined;

    usef_ram #(
        .WIDTH (EW),
        .DEPTH (VERTEX_COUNT)
    ) u_parent (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Decode the entry read in the previous cycle
    assign w_root = w_rd_data[AW];
    assign w_pay  = w_rd_data[AW-1:0];

    // Order endpoints and screen self-loops and out-of-range vertices
    assign w_a_lt_b = i_vertex_a < i_vertex_b;
    assign w_lo_in  = w_a_lt_b ? i_vertex_a : i_vertex_b;
    assign w_hi_in  = w_a_lt_b ? i_vertex_b : i_vertex_a;
    assign w_in_ok  = (w_lo_in != w_hi_in) && (32'(w_hi_in) < 32'(VERTEX_COUNT));

    // Join rule: the high root wins only when its tree is strictly larger
    assign w_ri_wins = !(r_sj > r_si);
    assign w_joined  = t_addr'({1'b0, r_si} + {1'b0, r_sj} + {{AW{1'b0}}, 1'b1});

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_cur     = r_cur;
        n_ri      = r_ri;
        n_rj      = r_rj;
        n_si      = r_si;
        n_sj      = r_sj;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_keep    = r_keep;
        w_rd_en   = 1'b0;
        w_rd_addr = r_cur;
        w_wr_en   = 1'b0;
        w_wr_addr = r_cur;
        w_wr_data = ROOT_ONE;
        case (r_state)
            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr;
                w_wr_data = ROOT_ONE;
                n_clr     = r_clr + t_addr'(1);
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_lo   = w_lo_in;
                    n_hi   = w_hi_in;
                    n_keep = 1'b0;
                    if (w_in_ok) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = t_addr'(w_lo_in);
                        n_cur     = t_addr'(w_lo_in);
                        n_state   = S_FIND_LO;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FIND_LO: begin
                w_rd_en = 1'b1;
                if (w_root) begin
                    n_ri      = r_cur;
                    n_si      = w_pay;
                    w_rd_addr = t_addr'(r_hi);
                    n_cur     = t_addr'(r_hi);
                    n_state   = S_FIND_HI;
                end else begin
                    w_rd_addr = w_pay;
                    n_cur     = w_pay;
                end
            end
            S_FIND_HI: begin
                w_rd_en = 1'b1;
                if (w_root) begin
                    n_rj      = r_cur;
                    n_sj      = w_pay;
                    w_rd_addr = t_addr'(r_lo);
                    n_cur     = t_addr'(r_lo);
                    n_state   = S_COMP_LO;
                end else begin
                    w_rd_addr = w_pay;
                    n_cur     = w_pay;
                end
            end
            S_COMP_LO: begin
                w_rd_en = 1'b1;
                if (w_root) begin
                    w_rd_addr = t_addr'(r_hi);
                    n_cur     = t_addr'(r_hi);
                    n_state   = S_COMP_HI;
                end else begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_cur;
                    w_wr_data = {1'b0, r_ri};
                    w_rd_addr = w_pay;
                    n_cur     = w_pay;
                end
            end
            S_COMP_HI: begin
                if (w_root) begin
                    n_state = (r_ri != r_rj) ? S_LINK_ROOT : S_DONE;
                end else begin
                    w_rd_en   = 1'b1;
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_cur;
                    w_wr_data = {1'b0, r_rj};
                    w_rd_addr = w_pay;
                    n_cur     = w_pay;
                end
            end
            S_LINK_ROOT: begin
                w_wr_en   = 1'b1;
                w_wr_addr = w_ri_wins ? r_ri : r_rj;
                w_wr_data = {1'b1, w_joined};
                n_state   = S_LINK_CHILD;
            end
            S_LINK_CHILD: begin
                w_wr_en   = 1'b1;
                w_wr_addr = w_ri_wins ? r_rj : r_ri;
                w_wr_data = {1'b0, (w_ri_wins ? r_ri : r_rj)};
                n_keep    = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    // Walk and root registers
    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_ri   <= n_ri;
        r_rj   <= n_rj;
        r_si   <= n_si;
        r_sj   <= n_sj;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_keep <= n_keep;
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE) && i_out_free;
    assign o_stat.keep = r_keep;
    assign o_stat.lo   = r_lo;
    assign o_stat.hi   = r_hi;

endmodule
